@@ hdl/rcf_pkg.sv @@
// Shared types and constants of the RGB convolution filter.
package rcf_pkg;

	localparam int PIX_W      = 8;
	localparam int CH         = 3;
	localparam int PIXEL_W    = PIX_W * CH;
	localparam int COEF_W     = 20;
	localparam int PROD_W     = COEF_W + PIX_W + 1;
	localparam int FULL_SCALE = 255;
	localparam int CFG_W      = 13;
	localparam int IN_DATA_W  = 56;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 24;

	// Operation codes carried in the input tuser.
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_PIXEL = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_HEIGHT = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_KERNEL = 2'd2;

	typedef struct packed {
		logic valid;
		logic last;
	} stage_ctl_t;

endpackage

@@ hdl/rcf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rcf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/rcf_lane.sv @@
// One kernel row: products of a window row with its coefficients, then the row sum.
module rcf_lane #(
	parameter int MAX_KERNEL = 5,
	parameter int ROW = 0,
	localparam int KW = $clog2(MAX_KERNEL + 1),
	localparam int LSUM_W = rcf_pkg::PROD_W + $clog2(MAX_KERNEL)
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [KW-1:0]                     k,
	input  logic [rcf_pkg::PIXEL_W-1:0]       pix [MAX_KERNEL],
	input  logic signed [rcf_pkg::COEF_W-1:0] coef [MAX_KERNEL],
	output logic signed [LSUM_W-1:0]          row_sum [rcf_pkg::CH]
);
	import rcf_pkg::*;

	logic signed [PROD_W-1:0] prod_s1 [MAX_KERNEL][CH];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int b = 0; b < MAX_KERNEL; b++) begin
				for (int ch = 0; ch < CH; ch++) begin
					// drop taps outside the kernel in use
					if (k > KW'(ROW) && k > KW'(b)) begin
						prod_s1[b][ch] <= $signed({1'b0, pix[b][ch*PIX_W +: PIX_W]}) * coef[b];
					end else begin
						prod_s1[b][ch] <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < CH; ch++) begin
				logic signed [LSUM_W-1:0] acc;
				acc = '0;
				for (int b = 0; b < MAX_KERNEL; b++) begin
					acc = acc + LSUM_W'(prod_s1[b][ch]);
				end
				row_sum[ch] <= acc;
			end
		end
	end

endmodule

@@ hdl/rcf_merge.sv @@
// Adds the lane sums, drops the fraction, clamps and holds the output register.
module rcf_merge #(
	parameter int MAX_KERNEL = 5,
	parameter int COEF_FRAC_BITS = 10,
	localparam int LSUM_W = rcf_pkg::PROD_W + $clog2(MAX_KERNEL),
	localparam int TSUM_W = LSUM_W + $clog2(MAX_KERNEL)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  rcf_pkg::stage_ctl_t               ctl,
	input  logic signed [LSUM_W-1:0]          lane_sum [MAX_KERNEL][rcf_pkg::CH],
	output logic                              out_valid,
	output logic                              out_last,
	output logic [rcf_pkg::OUT_DATA_W-1:0]    out_rgb
);
	import rcf_pkg::*;

	function automatic logic [PIX_W-1:0] clamp_px(input logic signed [TSUM_W-1:0] tot);
		logic signed [TSUM_W-1:0] sh;
		sh = tot >>> COEF_FRAC_BITS;
		if (tot <= 0) begin
			return '0;
		end else if (sh > $signed(TSUM_W'(FULL_SCALE))) begin
			return PIX_W'(FULL_SCALE);
		end else begin
			return sh[PIX_W-1:0];
		end
	endfunction

	logic [OUT_DATA_W-1:0] rgb_next;

	always_comb begin
		for (int ch = 0; ch < CH; ch++) begin
			logic signed [TSUM_W-1:0] tot;
			tot = '0;
			for (int a = 0; a < MAX_KERNEL; a++) begin
				tot = tot + TSUM_W'(lane_sum[a][ch]);
			end
			rgb_next[ch*PIX_W +: PIX_W] = clamp_px(tot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctl.valid) begin
			out_rgb  <= rgb_next;
			out_last <= ctl.last;
		end
	end

endmodule

@@ hdl/rgb_convolution_filter_unit.sv @@
// Each result passes the fetch, RAM read, window, product, row-sum and output registers;
// a row's first position first fetches (kernel_size-1-kernel_size/2) further columns.
// Throughput: one request per cycle unless the output stalls; at a row start input holds
// while the window fetches its leading columns through the single read port of the line
// RAMs. A coefficient load holds until windows in flight have read the coefficient registers.
// Reset: asynchronous, clears counters, coefficients and pipeline valids; line RAM has none.
module rgb_convolution_filter_unit #(
	parameter int MAX_KERNEL = 5,
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 4096,
	parameter int COEF_FRAC_BITS = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// coef_index, coef_value, red_in, green_in, blue_in
	input  logic [rcf_pkg::IN_DATA_W-1:0]    s_tdata,
	// operation
	input  logic [rcf_pkg::IN_USER_W-1:0]    s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// red_out, green_out, blue_out
	output logic [rcf_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [rcf_pkg::CFG_W-1:0]        cfg_wdata
);
	import rcf_pkg::*;

	localparam int KW     = $clog2(MAX_KERNEL + 1);
	localparam int TAPS   = MAX_KERNEL * MAX_KERNEL;
	localparam int L      = MAX_KERNEL + 4;
	localparam int LW     = $clog2(L);
	localparam int RW     = $clog2(MAX_HEIGHT + 1);
	localparam int CW     = $clog2(MAX_WIDTH + 1);
	localparam int AW     = $clog2(MAX_WIDTH);
	localparam int TW     = LW + 2;
	localparam int LSUM_W = PROD_W + $clog2(MAX_KERNEL);

	function automatic logic [RW-1:0] eff_height(input logic [12:0] x);
		int unsigned v;
		v = 32'(x);
		if (v == 0) v = 1;
		else if (v > MAX_HEIGHT) v = MAX_HEIGHT;
		return RW'(v);
	endfunction

	function automatic logic [CW-1:0] eff_width(input logic [10:0] x);
		int unsigned v;
		v = 32'(x);
		if (v == 0) v = 1;
		else if (v > MAX_WIDTH) v = MAX_WIDTH;
		return CW'(v);
	endfunction

	function automatic logic [KW-1:0] eff_kernel(input logic [2:0] x);
		int unsigned v;
		v = 32'(x);
		if (v > MAX_KERNEL) v = MAX_KERNEL;
		return KW'(v);
	endfunction

	// configuration
	logic [RW-1:0] h_q;
	logic [CW-1:0] w_q;
	logic [KW-1:0] k_q;
	logic [KW-1:0] lo, hi;

	// frame counters
	logic [RW-1:0] rrow_q, erow_q;
	logic [AW-1:0] rcol_q, ecol_q;
	logic [LW-1:0] rring_q, ering_q;

	logic signed [COEF_W-1:0] coef_q [TAPS];

	// input decode
	logic [1:0] op;
	logic is_load, is_pix, is_emit_op, take_pix, rcol_wrap;
	logic accept, emit, e_last, can_emit, ready, advance, pipe_busy;
	logic [RW-1:0] nrrow, nr;
	logic [AW-1:0] nrcol;
	logic [CW-1:0] nc;
	logic [RW:0] er_hi;
	logic [CW:0] ec_hi, first_col;
	logic [PIXEL_W-1:0] pix_in;
	logic [MAX_KERNEL-1:0] row_mask;
	logic [LW-1:0] row_ring [MAX_KERNEL];

	// column fetch sequencer and stages
	logic [KW-1:0] seq_left_q, seq_col_q;
	logic [MAX_KERNEL-1:0] seq_mask_q;
	logic [LW-1:0] seq_ring_q [MAX_KERNEL];
	logic seq_last_q;

	logic f_valid_s1, f_colok_s1, f_clear_s1, f_final_s1, f_last_s1;
	logic [AW-1:0] f_addr_s1;
	logic [MAX_KERNEL-1:0] f_mask_s1;
	logic [LW-1:0] f_ring_s1 [MAX_KERNEL];

	logic f_valid_s2, f_colok_s2, f_clear_s2, f_final_s2, f_last_s2;
	logic [MAX_KERNEL-1:0] f_mask_s2;
	logic [LW-1:0] f_ring_s2 [MAX_KERNEL];

	logic [PIXEL_W-1:0] ram_q [L];
	logic [PIXEL_W-1:0] col_px [MAX_KERNEL];
	logic [PIXEL_W-1:0] win_q [MAX_KERNEL][MAX_KERNEL];
	logic [PIXEL_W-1:0] win_shift [MAX_KERNEL][MAX_KERNEL];

	stage_ctl_t ctl_w_q, ctl_m1_q, ctl_m2_q;
	logic signed [LSUM_W-1:0] lane_sum [MAX_KERNEL][CH];

	assign op         = s_tuser;
	assign is_load    = (op == OP_LOAD);
	assign is_pix     = (op == OP_PIXEL);
	assign is_emit_op = (op == OP_PIXEL) || (op == OP_FLUSH);
	assign pix_in     = {s_tdata[48:41], s_tdata[40:33], s_tdata[32:25]};

	assign lo = k_q >> 1;
	assign hi = (k_q == '0) ? '0 : KW'(k_q - KW'(1) - lo);

	assign advance   = !m_tvalid || m_tready;
	assign pipe_busy = (seq_left_q != '0) || f_valid_s1 || f_valid_s2 || ctl_w_q.valid;
	assign s_tready  = advance && (seq_left_q == '0) && !(is_load && pipe_busy);
	assign accept    = s_tvalid && s_tready;

	// receive position after this request
	assign take_pix  = is_pix && (rrow_q < h_q);
	assign rcol_wrap = (CW'(rcol_q) + CW'(1)) == w_q;

	always_comb begin
		nrrow = rrow_q;
		nrcol = rcol_q;
		if (take_pix) begin
			if (rcol_wrap) begin
				nrrow = rrow_q + RW'(1);
				nrcol = '0;
			end else begin
				nrcol = rcol_q + AW'(1);
			end
		end
	end

	// last pixel the emit position needs, clamped to the frame
	assign er_hi = (RW+1)'(erow_q) + (RW+1)'(hi);
	assign ec_hi = (CW+1)'(ecol_q) + (CW+1)'(hi);
	assign nr    = (er_hi > (RW+1)'(h_q - RW'(1))) ? RW'(h_q - RW'(1)) : er_hi[RW-1:0];
	assign nc    = (ec_hi > (CW+1)'(w_q - CW'(1))) ? CW'(w_q - CW'(1)) : ec_hi[CW-1:0];
	assign ready = (nrrow > nr) || ((nrrow == nr) && (CW'(nrcol) > nc));

	assign can_emit  = (erow_q < h_q) && ready;
	assign emit      = accept && is_emit_op && can_emit;
	assign e_last    = (erow_q == RW'(h_q - RW'(1))) && (CW'(ecol_q) == CW'(w_q - CW'(1)));
	assign first_col = (ecol_q == '0) ? '0 : ec_hi;

	// kernel rows of the emit position: frame check and ring row
	always_comb begin
		for (int a = 0; a < MAX_KERNEL; a++) begin
			logic [RW:0] s;
			logic [TW-1:0] t;
			s = (RW+1)'(erow_q) + (RW+1)'(a);
			row_mask[a] = (k_q > KW'(a)) && (s >= (RW+1)'(lo))
			              && ((s - (RW+1)'(lo)) < (RW+1)'(h_q));
			t = TW'(ering_q) + TW'(L) - TW'(lo) + TW'(a);
			if (t >= TW'(2 * L)) t = t - TW'(2 * L);
			else if (t >= TW'(L)) t = t - TW'(L);
			row_ring[a] = t[LW-1:0];
		end
	end

	// configuration and frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q     <= RW'(1);
			w_q     <= CW'(1);
			k_q     <= eff_kernel(3'd3);
			rrow_q  <= '0;
			rcol_q  <= '0;
			rring_q <= '0;
			erow_q  <= '0;
			ecol_q  <= '0;
			ering_q <= '0;
		end else if (cfg_we && (cfg_index == REG_HEIGHT || cfg_index == REG_WIDTH
		                        || cfg_index == REG_KERNEL)) begin
			unique case (cfg_index)
				REG_HEIGHT: h_q <= eff_height(cfg_wdata[12:0]);
				REG_WIDTH:  w_q <= eff_width(cfg_wdata[10:0]);
				default:    k_q <= eff_kernel(cfg_wdata[2:0]);
			endcase
			rrow_q  <= '0;
			rcol_q  <= '0;
			rring_q <= '0;
			erow_q  <= '0;
			ecol_q  <= '0;
			ering_q <= '0;
		end else if (accept) begin
			if (emit && e_last) begin
				// frame done: restart both sides
				rrow_q  <= '0;
				rcol_q  <= '0;
				rring_q <= '0;
				erow_q  <= '0;
				ecol_q  <= '0;
				ering_q <= '0;
			end else begin
				if (take_pix) begin
					rrow_q <= nrrow;
					rcol_q <= nrcol;
					if (rcol_wrap) begin
						rring_q <= (rring_q == LW'(L - 1)) ? '0 : rring_q + LW'(1);
					end
				end
				if (emit) begin
					if (CW'(ecol_q) == CW'(w_q - CW'(1))) begin
						ecol_q  <= '0;
						erow_q  <= erow_q + RW'(1);
						ering_q <= (ering_q == LW'(L - 1)) ? '0 : ering_q + LW'(1);
					end else begin
						ecol_q <= ecol_q + AW'(1);
					end
				end
			end
		end
	end

	// coefficient store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < TAPS; t++) begin
				coef_q[t] <= '0;
			end
		end else if (accept && is_load) begin
			for (int t = 0; t < TAPS; t++) begin
				if (s_tdata[4:0] == 5'(t)) begin
					coef_q[t] <= $signed(s_tdata[24:5]);
				end
			end
		end
	end

	// line RAMs, one per ring row
	for (genvar i = 0; i < L; i++) begin : g_line
		rcf_ram #(
			.WIDTH(PIXEL_W),
			.DEPTH(MAX_WIDTH)
		) u_ram (
			.clk  (clk),
			.we   (accept && take_pix && (rring_q == LW'(i))),
			.waddr(rcol_q),
			.wdata(pix_in),
			.re   (advance),
			.raddr(f_addr_s1),
			.rdata(ram_q[i])
		);
	end

	// fetch request: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_valid_s1 <= 1'b0;
			seq_left_q <= '0;
		end else if (advance) begin
			if (seq_left_q != '0) begin
				f_valid_s1 <= 1'b1;
				seq_left_q <= seq_left_q - KW'(1);
			end else if (emit) begin
				f_valid_s1 <= 1'b1;
				if (ecol_q == '0) begin
					seq_left_q <= hi;
				end
			end else begin
				f_valid_s1 <= 1'b0;
			end
		end
	end

	// fetch request: payload
	always_ff @(posedge clk) begin
		if (advance) begin
			if (seq_left_q != '0) begin
				f_addr_s1  <= AW'(seq_col_q);
				f_colok_s1 <= CW'(seq_col_q) < w_q;
				f_clear_s1 <= 1'b0;
				f_final_s1 <= (seq_left_q == KW'(1));
				f_last_s1  <= seq_last_q;
				f_mask_s1  <= seq_mask_q;
				f_ring_s1  <= seq_ring_q;
				seq_col_q  <= seq_col_q + KW'(1);
			end else if (emit) begin
				f_addr_s1  <= first_col[AW-1:0];
				f_colok_s1 <= first_col < (CW+1)'(w_q);
				f_clear_s1 <= (ecol_q == '0);
				f_final_s1 <= !((ecol_q == '0) && (hi != '0));
				f_last_s1  <= e_last;
				f_mask_s1  <= row_mask;
				f_ring_s1  <= row_ring;
				seq_col_q  <= KW'(1);
				seq_last_q <= e_last;
				seq_mask_q <= row_mask;
				seq_ring_q <= row_ring;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_valid_s2 <= 1'b0;
		end else if (advance) begin
			f_valid_s2 <= f_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			f_colok_s2 <= f_colok_s1;
			f_clear_s2 <= f_clear_s1;
			f_final_s2 <= f_final_s1;
			f_last_s2  <= f_last_s1;
			f_mask_s2  <= f_mask_s1;
			f_ring_s2  <= f_ring_s1;
		end
	end

	// new window column; zero outside the frame
	always_comb begin
		for (int a = 0; a < MAX_KERNEL; a++) begin
			col_px[a] = (f_mask_s2[a] && f_colok_s2) ? ram_q[f_ring_s2[a]] : '0;
		end
	end

	for (genvar a = 0; a < MAX_KERNEL; a++) begin : g_shift_row
		for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_shift_col
			if (b < MAX_KERNEL - 1) begin : g_mid
				assign win_shift[a][b] = win_q[a][b+1];
			end else begin : g_end
				assign win_shift[a][b] = '0;
			end
		end
	end

	// window: shift left, new column enters at slot k-1
	always_ff @(posedge clk) begin
		if (advance && f_valid_s2 && (k_q != '0)) begin
			for (int a = 0; a < MAX_KERNEL; a++) begin
				for (int b = 0; b < MAX_KERNEL; b++) begin
					if (KW'(b) == KW'(k_q - KW'(1))) begin
						win_q[a][b] <= col_px[a];
					end else if (KW'(b) < KW'(k_q - KW'(1))) begin
						win_q[a][b] <= f_clear_s2 ? '0 : win_shift[a][b];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_w_q  <= '0;
			ctl_m1_q <= '0;
			ctl_m2_q <= '0;
		end else if (advance) begin
			ctl_w_q.valid <= f_valid_s2 && f_final_s2;
			ctl_w_q.last  <= f_last_s2;
			ctl_m1_q      <= ctl_w_q;
			ctl_m2_q      <= ctl_m1_q;
		end
	end

	for (genvar a = 0; a < MAX_KERNEL; a++) begin : g_lane
		logic signed [COEF_W-1:0] coef_row [MAX_KERNEL];

		for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_coef
			assign coef_row[b] = coef_q[a*MAX_KERNEL + b];
		end

		rcf_lane #(
			.MAX_KERNEL(MAX_KERNEL),
			.ROW(a)
		) u_lane (
			.clk    (clk),
			.en     (advance),
			.k      (k_q),
			.pix    (win_q[a]),
			.coef   (coef_row),
			.row_sum(lane_sum[a])
		);
	end

	rcf_merge #(
		.MAX_KERNEL(MAX_KERNEL),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.ctl      (ctl_m2_q),
		.lane_sum (lane_sum),
		.out_valid(m_tvalid),
		.out_last (m_tlast),
		.out_rgb  (m_tdata)
	);

endmodule

@@ hdl/rcf_checker.sv @@
// Port-level checks of the RGB convolution filter and their binding.
module rcf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// a blocked output stalls the whole pipe, so no request may enter
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("request taken while output stalled");

	a_reset_clears: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result valid during reset");

endmodule

bind rgb_convolution_filter_unit rcf_checker u_rcf_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
